// ===== rtl/core/fbfa_pkg.sv =====
// Shared constants, codes and the result bundle for the block allocator.
// No dependencies; fbfa_core and the top module use this package.
`default_nettype none

package fbfa_pkg;

    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int COUNTER_BITS_DEF = 32;
    localparam int BLOCKS_RESET     = 16;

    localparam int CFG_W    = 9;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int LEVEL_W  = 9;
    localparam int EVENT_W  = 32;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_FREE  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_index;
        logic [LEVEL_W-1:0]  free_blocks_now;
        logic [LEVEL_W-1:0]  outstanding_blocks;
        logic [EVENT_W-1:0]  allocations_done;
        logic [EVENT_W-1:0]  frees_done;
        logic [EVENT_W-1:0]  failed_allocations;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/fbfa_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on nothing; used for the link store and the allocated map.
`default_nettype none

module fbfa_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fbfa_core.sv =====
// Pool state and the per-item decision: list head, fresh index, levels, event counters.
// Depends on fbfa_pkg; consumes read data from the two fbfa_ram instances.
`default_nettype none

module fbfa_core #(
    parameter int MAX_BLOCKS   = fbfa_pkg::MAX_BLOCKS_DEF,
    parameter int COUNTER_BITS = fbfa_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [fbfa_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              exec,
    input  wire logic                              op_action,
    input  wire logic [fbfa_pkg::INDEX_W-1:0]      op_index,
    input  wire logic                              map_rdata,
    input  wire logic [$clog2(MAX_BLOCKS)-1:0]     link_rdata,
    output logic      [$clog2(MAX_BLOCKS)-1:0]     head_index,
    output logic                                   map_we,
    output logic      [$clog2(MAX_BLOCKS)-1:0]     map_waddr,
    output logic                                   map_wdata,
    output logic                                   link_we,
    output logic      [$clog2(MAX_BLOCKS)-1:0]     link_waddr,
    output logic      [$clog2(MAX_BLOCKS)-1:0]     link_wdata,
    output fbfa_pkg::result_t                      result
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int PW = $clog2(MAX_BLOCKS + 1);
    localparam int CW = (PW > fbfa_pkg::INDEX_W) ? PW : fbfa_pkg::INDEX_W;

    function automatic logic [PW-1:0] pool_size(input logic [fbfa_pkg::CFG_W-1:0] v);
        logic [PW-1:0] f;
        if (32'(v) > MAX_BLOCKS)
            f = PW'(MAX_BLOCKS);
        else
            f = PW'(v);
        return f;
    endfunction

    logic [fbfa_pkg::CFG_W-1:0] blocks_in_use_reg;
    logic                       head_valid_reg, head_valid_next;
    logic [IW-1:0]              head_reg, head_next;
    logic [PW-1:0]              next_fresh_reg, next_fresh_next;
    logic [PW-1:0]              free_total_reg, free_total_next;
    logic [PW-1:0]              outstanding_reg, outstanding_next;
    logic [COUNTER_BITS-1:0]    alloc_cnt_reg, alloc_cnt_next;
    logic [COUNTER_BITS-1:0]    free_cnt_reg, free_cnt_next;
    logic [COUNTER_BITS-1:0]    fail_cnt_reg, fail_cnt_next;

    logic [PW-1:0]                   pool_n;
    logic [PW-1:0]                   fresh_left;
    logic [PW-1:0]                   recycled;
    logic                            index_held;
    logic [IW-1:0]                   granted;
    logic [fbfa_pkg::STATUS_W-1:0]   status;

    assign pool_n     = pool_size(blocks_in_use_reg);
    assign fresh_left = pool_n - next_fresh_reg;
    assign recycled   = free_total_reg - fresh_left;
    // Indices at or above the fresh count were never handed out since init.
    assign index_held = (CW'(op_index) < CW'(next_fresh_reg)) && map_rdata;
    assign head_index = head_reg;

    always_comb
    begin
        head_valid_next  = head_valid_reg;
        head_next        = head_reg;
        next_fresh_next  = next_fresh_reg;
        free_total_next  = free_total_reg;
        outstanding_next = outstanding_reg;
        alloc_cnt_next   = alloc_cnt_reg;
        free_cnt_next    = free_cnt_reg;
        fail_cnt_next    = fail_cnt_reg;
        granted          = '0;
        status           = fbfa_pkg::STAT_OK;
        map_we           = 1'b0;
        map_waddr        = IW'(op_index);
        map_wdata        = 1'b0;
        link_we          = 1'b0;
        link_waddr       = IW'(op_index);
        link_wdata       = head_valid_reg ? head_reg : '0;

        if (op_action == fbfa_pkg::ACT_ALLOC)
        begin
            if ((recycled != '0) && head_valid_reg)
            begin
                granted = head_reg;
                if (recycled == PW'(1))
                    head_valid_next = 1'b0;
                else
                    head_next = link_rdata;
            end
            else if (fresh_left != '0)
            begin
                granted         = IW'(next_fresh_reg);
                next_fresh_next = next_fresh_reg + PW'(1);
            end
            else
            begin
                status = fbfa_pkg::STAT_EXHAUSTED;
            end

            if (status == fbfa_pkg::STAT_OK)
            begin
                map_we           = exec;
                map_waddr        = granted;
                map_wdata        = 1'b1;
                free_total_next  = free_total_reg - PW'(1);
                outstanding_next = outstanding_reg + PW'(1);
                alloc_cnt_next   = alloc_cnt_reg + COUNTER_BITS'(1);
            end
            else
            begin
                fail_cnt_next = fail_cnt_reg + COUNTER_BITS'(1);
            end
        end
        else
        begin
            if (!index_held)
            begin
                status = fbfa_pkg::STAT_BAD_FREE;
            end
            else
            begin
                // Push onto the list head; the old head becomes this block's link.
                link_we          = exec;
                map_we           = exec;
                head_valid_next  = 1'b1;
                head_next        = IW'(op_index);
                free_total_next  = free_total_reg + PW'(1);
                outstanding_next = outstanding_reg - PW'(1);
                free_cnt_next    = free_cnt_reg + COUNTER_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= fbfa_pkg::CFG_W'(fbfa_pkg::BLOCKS_RESET);
            head_valid_reg    <= 1'b0;
            head_reg          <= '0;
            next_fresh_reg    <= '0;
            free_total_reg    <= pool_size(fbfa_pkg::CFG_W'(fbfa_pkg::BLOCKS_RESET));
            outstanding_reg   <= '0;
            alloc_cnt_reg     <= '0;
            free_cnt_reg      <= '0;
            fail_cnt_reg      <= '0;
        end
        else if (cfg_write)
        begin
            // Re-initialize the pool, keep the event counters.
            blocks_in_use_reg <= cfg_data;
            head_valid_reg    <= 1'b0;
            next_fresh_reg    <= '0;
            free_total_reg    <= pool_size(cfg_data);
            outstanding_reg   <= '0;
        end
        else if (exec)
        begin
            head_valid_reg  <= head_valid_next;
            head_reg        <= head_next;
            next_fresh_reg  <= next_fresh_next;
            free_total_reg  <= free_total_next;
            outstanding_reg <= outstanding_next;
            alloc_cnt_reg   <= alloc_cnt_next;
            free_cnt_reg    <= free_cnt_next;
            fail_cnt_reg    <= fail_cnt_next;
        end
    end

    always_comb
    begin
        result.status             = status;
        result.granted_index      = fbfa_pkg::INDEX_W'(granted);
        result.free_blocks_now    = fbfa_pkg::LEVEL_W'(free_total_next);
        result.outstanding_blocks = fbfa_pkg::LEVEL_W'(outstanding_next);
        result.allocations_done   = fbfa_pkg::EVENT_W'(alloc_cnt_next);
        result.frees_done         = fbfa_pkg::EVENT_W'(free_cnt_next);
        result.failed_allocations = fbfa_pkg::EVENT_W'(fail_cnt_next);
    end

endmodule

`default_nettype wire

// ===== rtl/core/fixed_block_free_list_allocator_top.sv =====
// Fixed-size block allocator: takes one item at a time and is busy in its EXEC step; done is registered from EXEC.
// The pace is set by the link RAM read: the list head's link must return before the head moves.
// The receiver cannot stall; done flags each result for exactly one cycle, and the result stays on the ports.
// Reset (async, active low) restores a 16-block pool with empty free list and zero counters.
// No clearing pass: allocated marks are only trusted below the fresh-index count.
// Depends on fbfa_pkg, fbfa_ram and fbfa_core.
`default_nettype none

module fixed_block_free_list_allocator_top #(
    parameter int MAX_BLOCKS   = fbfa_pkg::MAX_BLOCKS_DEF,
    parameter int COUNTER_BITS = fbfa_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration: pool size, re-initializes the pool when written
    input  wire logic                               cfg_write,
    input  wire logic [fbfa_pkg::CFG_W-1:0]         cfg_data,
    // request item
    input  wire logic                               start,
    input  wire logic                               action,
    input  wire logic [fbfa_pkg::INDEX_W-1:0]       block_index,
    output logic                                    busy,
    // result item
    output logic                                    done,
    output logic      [fbfa_pkg::STATUS_W-1:0]      status,
    output logic      [fbfa_pkg::INDEX_W-1:0]       granted_index,
    output logic      [fbfa_pkg::LEVEL_W-1:0]       free_blocks_now,
    output logic      [fbfa_pkg::LEVEL_W-1:0]       outstanding_blocks,
    output logic      [fbfa_pkg::EVENT_W-1:0]       allocations_done,
    output logic      [fbfa_pkg::EVENT_W-1:0]       frees_done,
    output logic      [fbfa_pkg::EVENT_W-1:0]       failed_allocations
);

    localparam int IW = $clog2(MAX_BLOCKS);

    // Two-step sequence: IDLE takes the item and launches the RAM reads,
    // EXEC sees the read data, writes back and updates the pool state.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic                          accept;
    logic                          exec;
    logic                          action_reg;
    logic [fbfa_pkg::INDEX_W-1:0]  index_reg;
    logic                          done_reg;
    fbfa_pkg::result_t             result_reg;
    fbfa_pkg::result_t             core_result;

    logic [IW-1:0] head_index;
    logic          map_rdata;
    logic [IW-1:0] link_rdata;
    logic          map_we;
    logic [IW-1:0] map_waddr;
    logic          map_wdata;
    logic          link_we;
    logic [IW-1:0] link_waddr;
    logic [IW-1:0] link_wdata;

    assign busy   = (state_reg == S_EXEC);
    assign accept = start && !busy;
    assign exec   = (state_reg == S_EXEC);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
        end
    end

    // Hold the request operands for the EXEC step; register the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            index_reg  <= block_index;
        end
        if (exec)
        begin
            result_reg <= core_result;
        end
    end

    // Allocated marks, read at the index a free names.
    fbfa_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (1)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (accept),
        .raddr (IW'(block_index)),
        .rdata (map_rdata)
    );

    // Free-list links, read at the current list head.
    fbfa_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (IW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (head_index),
        .rdata (link_rdata)
    );

    fbfa_core #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .exec       (exec),
        .op_action  (action_reg),
        .op_index   (index_reg),
        .map_rdata  (map_rdata),
        .link_rdata (link_rdata),
        .head_index (head_index),
        .map_we     (map_we),
        .map_waddr  (map_waddr),
        .map_wdata  (map_wdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .result     (core_result)
    );

    assign done               = done_reg;
    assign status             = result_reg.status;
    assign granted_index      = result_reg.granted_index;
    assign free_blocks_now    = result_reg.free_blocks_now;
    assign outstanding_blocks = result_reg.outstanding_blocks;
    assign allocations_done   = result_reg.allocations_done;
    assign frees_done         = result_reg.frees_done;
    assign failed_allocations = result_reg.failed_allocations;

`ifndef SYNTHESIS
    // A result only follows an EXEC step.
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding execute step");

    // An accepted item always enters the execute step.
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter execute");

    // Only a successful allocate reports a nonzero block index.
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != fbfa_pkg::STAT_OK) |-> (granted_index == '0))
        else $error("nonzero granted index on a refused item");

    // A strobe is never held high back to back.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire
